### rtl/core/fphs_pkg.sv
// Shared widths, register indexes and phase codes for the four-phase handshake generator.
`timescale 1ns / 1ps
`default_nettype none
package fphs_pkg;

  // Field widths
  localparam int WORD_BITS  = 32;
  localparam int DELAY_BITS = 16;
  localparam int TIME_BITS  = 64;
  // Offset from item start to ack fall: sum of three delays
  localparam int OFF_BITS   = DELAY_BITS + 2;

  // Stream payload widths
  localparam int IN_TDATA_BITS   = ((WORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = TIME_BITS + WORD_BITS + 1;
  localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_ACK_BIT     = TIME_BITS + WORD_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ACK_RISE_DELAY   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DATA_CLEAR_DELAY = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACK_FALL_DELAY   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEUTRAL_WORD     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_ACK      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_TIME       = 3'd5;

  // Bit positions of the pending-transition mask
  localparam int PH_SNAP  = 0;
  localparam int PH_PLACE = 1;
  localparam int PH_RISE  = 2;
  localparam int PH_CLEAR = 3;
  localparam int PH_FALL  = 4;
  localparam int PH_COUNT = 5;

endpackage
`default_nettype wire

### rtl/core/four_phase_handshake_waveform_gen_top.sv
// Four-phase data/ack handshake waveform generator: top level.
//
// Each accepted word yields the timestamped line transitions of one four-phase
// handshake (word placed, ack high, data neutral, ack low), one transfer per
// cycle on the master stream unless m_tready stalls it, tlast on the final
// one; the first word after reset is preceded by the initial snapshot. A
// transition that repeats the previous line state is dropped, so a word gives
// two to four transfers (up to five with the snapshot), sent one at a time by
// the transition sequencer, which is the rate limit. The next word waits in
// an input register and enters the sequencer at the edge where its previous
// word's last transfer is loaded into the output register.
`timescale 1ns / 1ps
`default_nettype none
module four_phase_handshake_waveform_gen_top
  import fphs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Configuration write port
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  // Input stream
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,   // [31:0] data_word
  // Output stream
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,   // [63:0] sample_time, [95:64] sample_data,
                                                    // [96] sample_ack, rest zero
  output logic                           m_tlast    // last_of_run
);

  // Configuration registers
  logic [DELAY_BITS-1:0] rise_dly;
  logic [DELAY_BITS-1:0] clear_dly;
  logic [DELAY_BITS-1:0] fall_dly;
  logic [WORD_BITS-1:0]  idle_word;
  logic                  snap_ack_lvl;
  logic [TIME_BITS-1:0]  start_time;

  // Input register
  logic                  in_full;
  logic [WORD_BITS-1:0]  in_word;

  // Handshake state carried across words
  logic                  snap_done;
  logic [WORD_BITS-1:0]  last_data;

  // Sequencer state for the word in flight
  logic [PH_COUNT-1:0]   pend;
  logic [TIME_BITS-1:0]  base;
  logic [OFF_BITS-1:0]   off_rise;
  logic [OFF_BITS-1:0]   off_clear;
  logic [OFF_BITS-1:0]   off_fall;
  logic [WORD_BITS-1:0]  seq_word;
  logic [WORD_BITS-1:0]  seq_neutral;
  logic                  seq_snap_ack;
  logic                  seq_place_ack;

  // Combinational control
  logic [PH_COUNT-1:0]   sel;
  logic                  emit;
  logic                  seq_done;
  logic                  load;
  logic [WORD_BITS-1:0]  prior_data;
  logic                  prior_ack;
  logic [PH_COUNT-1:0]   pend_next;
  logic [OFF_BITS-1:0]   off_clear_next;
  logic [OFF_BITS-1:0]   off_fall_next;
  logic [TIME_BITS-1:0]  base_next;
  logic [OFF_BITS-1:0]   off_sel;
  logic [WORD_BITS-1:0]  data_sel;
  logic                  ack_sel;
  logic [TIME_BITS-1:0]  time_sel;

  // Configuration writes; out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_dly     <= DELAY_BITS'(1);
      clear_dly    <= '0;
      fall_dly     <= DELAY_BITS'(1);
      idle_word    <= '0;
      snap_ack_lvl <= 1'b0;
      start_time   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACK_RISE_DELAY:   rise_dly     <= cfg_wdata[DELAY_BITS-1:0];
        REG_DATA_CLEAR_DELAY: clear_dly    <= cfg_wdata[DELAY_BITS-1:0];
        REG_ACK_FALL_DELAY:   fall_dly     <= cfg_wdata[DELAY_BITS-1:0];
        REG_NEUTRAL_WORD:     idle_word    <= cfg_wdata[WORD_BITS-1:0];
        REG_INITIAL_ACK:      snap_ack_lvl <= cfg_wdata[0];
        REG_START_TIME:       start_time   <= cfg_wdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control: lowest pending transition goes out next
  always_comb begin
    sel      = pend & (~pend + PH_COUNT'(1));
    emit     = (pend != '0) && (!m_tvalid || m_tready);
    seq_done = (pend == '0) || (emit && (pend == sel));
    load     = in_full && seq_done;
  end

  // Decide at load which transitions survive the repeat check
  always_comb begin
    prior_data = snap_done ? last_data : idle_word;
    prior_ack  = snap_done ? 1'b0 : snap_ack_lvl;
    pend_next            = '0;
    pend_next[PH_SNAP]   = !snap_done;
    pend_next[PH_PLACE]  = (in_word != prior_data);
    pend_next[PH_RISE]   = !prior_ack;               // place keeps old ack
    pend_next[PH_CLEAR]  = (in_word != idle_word);
    pend_next[PH_FALL]   = 1'b1;                     // ack always drops from high
    off_clear_next = OFF_BITS'(rise_dly) + OFF_BITS'(clear_dly);
    off_fall_next  = off_clear_next + OFF_BITS'(fall_dly);
    // next word starts at the previous ack fall
    base_next = snap_done ? (base + TIME_BITS'(off_fall)) : start_time;
  end

  // Fields of the transition being sent
  always_comb begin
    off_sel  = '0;
    data_sel = seq_neutral;
    ack_sel  = 1'b0;
    if (sel[PH_SNAP]) begin
      ack_sel  = seq_snap_ack;
    end else if (sel[PH_PLACE]) begin
      data_sel = seq_word;
      ack_sel  = seq_place_ack;
    end else if (sel[PH_RISE]) begin
      off_sel  = off_rise;
      data_sel = seq_word;
      ack_sel  = 1'b1;
    end else if (sel[PH_CLEAR]) begin
      off_sel  = off_clear;
      ack_sel  = 1'b1;
    end else begin
      off_sel  = off_fall;
    end
    time_sel = base + TIME_BITS'(off_sel);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      snap_done <= 1'b0;
      pend      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end
      if (load) begin
        snap_done <= 1'b1;
        pend      <= pend_next;
      end else if (emit) begin
        pend <= pend & ~sel;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata[WORD_BITS-1:0];
    end
    if (load) begin
      last_data     <= idle_word;
      base          <= base_next;
      off_rise      <= OFF_BITS'(rise_dly);
      off_clear     <= off_clear_next;
      off_fall      <= off_fall_next;
      seq_word      <= in_word;
      seq_neutral   <= idle_word;
      seq_snap_ack  <= snap_ack_lvl;
      seq_place_ack <= prior_ack;
    end
    if (emit) begin
      m_tdata <= OUT_TDATA_BITS'({ack_sel, data_sel, time_sel});
      m_tlast <= (pend == sel);
    end
  end

  assign s_tready = !in_full;

endmodule
`default_nettype wire

### rtl/core/fphs_checker.sv
// Port-level checks for the four-phase handshake generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fphs_checker
  import fphs_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [OUT_TDATA_BITS-1:0] m_tdata,
  input wire logic                      m_tlast
);

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // The input register takes one word and closes until it moves on
  a_in_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted into a full register");

  // Every run ends on the ack fall
  a_last_ack_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[OUT_ACK_BIT])
    else $error("run ended with ack high");

endmodule

bind four_phase_handshake_waveform_gen_top fphs_checker u_fphs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
